>>> hw/rtl/dnsqp_pkg.sv
package dnsqp_pkg;

    localparam int unsigned DataWidth  = 8;
    localparam int unsigned WordWidth  = 16;
    localparam int unsigned KindWidth  = 2;
    localparam int unsigned ErrWidth   = 2;
    localparam int unsigned TdataWidth = 48;

    localparam logic [DataWidth-1:0] DOT_CHAR = 8'h2E;

    localparam logic [KindWidth-1:0] KIND_CHAR = 2'd0;
    localparam logic [KindWidth-1:0] KIND_DONE = 2'd1;
    localparam logic [KindWidth-1:0] KIND_ERR  = 2'd2;

    localparam logic [ErrWidth-1:0] ERR_OVERRUN = 2'd0;
    localparam logic [ErrWidth-1:0] ERR_UNTERM  = 2'd1;
    localparam logic [ErrWidth-1:0] ERR_NOROOM  = 2'd2;

    // The four tail states hold the type and class bytes, high byte first.
    typedef enum logic [2:0] {
        PH_LEN   = 3'd0,
        PH_LABEL = 3'd1,
        PH_TAIL0 = 3'd2,
        PH_TAIL1 = 3'd3,
        PH_TAIL2 = 3'd4,
        PH_TAIL3 = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [DataWidth-1:0]   label_remaining;
        logic                   name_started;
        logic [WordWidth-1:0]   type_value;
        logic [DataWidth-1:0]   class_high;
    } parse_state_t;

    typedef struct packed {
        logic                   valid;
        logic [KindWidth-1:0]   kind;
        logic [DataWidth-1:0]   name_char;
        logic [WordWidth-1:0]   record_type;
        logic [WordWidth-1:0]   record_class;
        logic [ErrWidth-1:0]    error_code;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:           PH_LEN,
        label_remaining: '0,
        name_started:    1'b0,
        type_value:      '0,
        class_high:      '0
    };

endpackage

>>> hw/rtl/dnsqp_step.sv
module dnsqp_step
    import dnsqp_pkg::*;
(
    input  parse_state_t          state_cur,
    input  logic [DataWidth-1:0]  data_byte,
    input  logic                  last_byte,
    output parse_state_t          state_new,
    output parse_result_t         result
);

    logic [DataWidth-1:0] rem_dec;

    assign rem_dec = state_cur.label_remaining - 1'b1;

    always_comb begin
        state_new = state_cur;
        unique case (state_cur.phase)
            PH_LEN: begin
                if (data_byte == '0) begin
                    state_new.phase = PH_TAIL0;
                end else begin
                    state_new.name_started    = 1'b1;
                    state_new.label_remaining = data_byte;
                    state_new.phase           = PH_LABEL;
                end
            end
            PH_LABEL: begin
                state_new.label_remaining = rem_dec;
                if (rem_dec == '0) begin
                    state_new.phase = PH_LEN;
                end
            end
            PH_TAIL0: begin
                state_new.type_value = {data_byte, {DataWidth{1'b0}}};
                state_new.phase      = PH_TAIL1;
            end
            PH_TAIL1: begin
                state_new.type_value = state_cur.type_value | {{DataWidth{1'b0}}, data_byte};
                state_new.phase      = PH_TAIL2;
            end
            PH_TAIL2: begin
                state_new.class_high = data_byte;
                state_new.phase      = PH_TAIL3;
            end
            PH_TAIL3: begin
                state_new.phase = PH_DONE;
            end
            default: begin
                state_new.phase = PH_DONE;
            end
        endcase
        if (last_byte) begin
            state_new = STATE_RESET;
        end
    end

    always_comb begin
        result = '0;
        unique case (state_cur.phase) inside
            PH_LEN: begin
                if (data_byte == '0) begin
                    if (last_byte) begin
                        result.valid      = 1'b1;
                        result.kind       = KIND_ERR;
                        result.error_code = ERR_NOROOM;
                    end
                end else if (last_byte) begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERR;
                    result.error_code = ERR_OVERRUN;
                end else if (state_cur.name_started) begin
                    result.valid     = 1'b1;
                    result.kind      = KIND_CHAR;
                    result.name_char = DOT_CHAR;
                end
            end
            PH_LABEL: begin
                result.valid = 1'b1;
                if (last_byte) begin
                    result.kind       = KIND_ERR;
                    result.error_code = (rem_dec != '0) ? ERR_OVERRUN : ERR_UNTERM;
                end else begin
                    result.kind      = KIND_CHAR;
                    result.name_char = data_byte;
                end
            end
            PH_TAIL0, PH_TAIL1, PH_TAIL2: begin
                if (last_byte) begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERR;
                    result.error_code = ERR_NOROOM;
                end
            end
            PH_TAIL3: begin
                result.valid        = 1'b1;
                result.kind         = KIND_DONE;
                result.record_type  = state_cur.type_value;
                result.record_class = {state_cur.class_high, data_byte};
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/dns_question_parser_core.sv
// DNS question parser.
// The slave channel carries one byte of a question buffer per request, with
// s_axis_tlast set on the final byte of the buffer. The master channel gives
// one result per name character, per dot between labels, per completed
// question (type and class) and per error; bytes that cause no result give
// nothing on the master side.
// Each byte passes an input register and then a result register. One byte
// is accepted every cycle while the master side takes results; the parse
// state is a single register updated in the same cycle that a byte leaves
// the input register.
// A byte with s_axis_tlast set returns the parser to the start of a name.
// Reset empties both registers and returns the parser to the start of a name.
// When the receiver stalls, the pending result holds steady, one more byte
// waits in the input register, and s_axis_tready then drops until the
// result is taken.
module dns_question_parser_core
    import dnsqp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DataWidth-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // last_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] name_char, [23:8] record_type, [39:24] record_class,
    // [41:40] error_code, [47:42] zero
    output logic [TdataWidth-1:0]  m_axis_tdata,
    output logic [KindWidth-1:0]   m_axis_tuser    // [1:0] out_kind
);

    logic                  in_valid_reg;
    logic [DataWidth-1:0]  in_byte_reg;
    logic                  in_last_reg;
    parse_state_t          state_reg;
    parse_state_t          state_next;
    parse_result_t         step_result;
    logic                  out_valid_reg;
    parse_result_t         out_reg;
    logic                  out_free;
    logic                  advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    dnsqp_step u_step (
        .state_cur (state_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .state_new (state_next),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= advance && step_result.valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {{(TdataWidth - 2*DataWidth - 2*WordWidth + DataWidth
                            - ErrWidth){1'b0}},
                            out_reg.error_code, out_reg.record_class,
                            out_reg.record_type, out_reg.name_char};

    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=>
            (state_reg.phase == PH_LEN && !state_reg.name_started))
        else $error("last byte did not return the parser to the start of a name");

    a_error_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step_result.valid && step_result.kind == KIND_ERR) |-> in_last_reg)
        else $error("error reported on a byte that does not end the buffer");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |->
            (m_axis_tdata[7:0] == '0 && m_axis_tdata[41:40] == '0))
        else $error("completion result carries a character or error code");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a pending blocked result");

endmodule

>>> tb/sv/dns_question_parser_core_tb.sv
`timescale 1ns / 100ps

module dns_question_parser_core_tb;
    import dnsqp_pkg::*;

    typedef logic [DataWidth-1:0] byte_q_t[$];

    typedef struct packed {
        logic [KindWidth-1:0] kind;
        logic [DataWidth-1:0] name_char;
        logic [WordWidth-1:0] record_type;
        logic [WordWidth-1:0] record_class;
        logic [ErrWidth-1:0]  error_code;
    } question_result_t;

    // Tracks the parse of the byte stream and holds the results still owed.
    class question_parse_tracker;
        question_result_t     pending_results[$];
        int unsigned          error_count = 0;
        phase_t               phase = PH_LEN;
        logic [DataWidth-1:0] label_left = '0;
        logic                 name_started = 1'b0;
        logic [WordWidth-1:0] type_word = '0;
        logic [DataWidth-1:0] class_hi = '0;

        function void note_request(logic [DataWidth-1:0] b, logic last);
            question_result_t r;
            logic             produced;
            r = '0;
            produced = 1'b0;
            case (phase) inside
                PH_LEN: begin
                    if (b == '0) begin
                        phase = PH_TAIL0;
                        if (last) begin
                            r.kind = KIND_ERR;
                            r.error_code = ERR_NOROOM;
                            produced = 1'b1;
                        end
                    end else begin
                        phase = PH_LABEL;
                        label_left = b;
                        if (last) begin
                            r.kind = KIND_ERR;
                            r.error_code = ERR_OVERRUN;
                            produced = 1'b1;
                        end else if (name_started) begin
                            r.kind = KIND_CHAR;
                            r.name_char = DOT_CHAR;
                            produced = 1'b1;
                        end
                        name_started = 1'b1;
                    end
                end
                PH_LABEL: begin
                    label_left = label_left - 1'b1;
                    if (label_left == '0) phase = PH_LEN;
                    produced = 1'b1;
                    if (last) begin
                        r.kind = KIND_ERR;
                        r.error_code = (label_left != '0) ? ERR_OVERRUN : ERR_UNTERM;
                    end else begin
                        r.kind = KIND_CHAR;
                        r.name_char = b;
                    end
                end
                PH_TAIL0, PH_TAIL1, PH_TAIL2: begin
                    if (phase == PH_TAIL0) begin
                        type_word = {b, 8'h00};
                        phase = PH_TAIL1;
                    end else if (phase == PH_TAIL1) begin
                        type_word[7:0] = b;
                        phase = PH_TAIL2;
                    end else begin
                        class_hi = b;
                        phase = PH_TAIL3;
                    end
                    if (last) begin
                        r.kind = KIND_ERR;
                        r.error_code = ERR_NOROOM;
                        produced = 1'b1;
                    end
                end
                PH_TAIL3: begin
                    r.kind = KIND_DONE;
                    r.record_type = type_word;
                    r.record_class = {class_hi, b};
                    produced = 1'b1;
                    phase = PH_DONE;
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
            if (produced) pending_results = {pending_results, r};
            if (last) begin
                phase = PH_LEN;
                label_left = '0;
                name_started = 1'b0;
                type_word = '0;
                class_hi = '0;
            end
        endfunction

        function void check_result(logic [KindWidth-1:0] kind, logic [TdataWidth-1:0] word);
            question_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got out_kind %0d tdata %h",
                         $time, kind, word);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (kind != want.kind) begin
                $display("%0t: out_kind expected %0d, got %0d", $time, want.kind, kind);
                error_count++;
            end
            if (word[7:0] != want.name_char) begin
                $display("%0t: name_char expected %h, got %h", $time, want.name_char,
                         word[7:0]);
                error_count++;
            end
            if (word[23:8] != want.record_type) begin
                $display("%0t: record_type expected %h, got %h", $time, want.record_type,
                         word[23:8]);
                error_count++;
            end
            if (word[39:24] != want.record_class) begin
                $display("%0t: record_class expected %h, got %h", $time, want.record_class,
                         word[39:24]);
                error_count++;
            end
            if (word[41:40] != want.error_code) begin
                $display("%0t: error_code expected %0d, got %0d", $time, want.error_code,
                         word[41:40]);
                error_count++;
            end
            if (word[47:42] != '0) begin
                $display("%0t: tdata padding expected 0, got %h", $time, word[47:42]);
                error_count++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DataWidth-1:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic                  s_axis_tlast = 1'b0; // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] name_char, [23:8] record_type, [39:24] record_class,
    // [41:40] error_code, [47:42] zero
    logic [TdataWidth-1:0] m_axis_tdata;
    logic [KindWidth-1:0]  m_axis_tuser;        // [1:0] out_kind

    question_parse_tracker tracker = new;

    int unsigned send_idle_pct = 23;
    int unsigned recv_idle_pct = 86;
    int unsigned requests_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    logic        hold_request = 1'b0;

    dns_question_parser_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_request(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_result(m_axis_tuser, m_axis_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= 3000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // The receiver counts out a long hold-off on request, else stalls at random.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
        end
        if (hold_left != 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [DataWidth-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tlast = last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic send_buffer(input byte_q_t bytes_q);
        foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge aclk);
    endtask

    function automatic byte_q_t make_question();
        byte_q_t     q;
        int unsigned len;
        int unsigned pick;
        repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(99);
            if (pick < 80) len = $urandom_range(1, 8);
            else if (pick < 97) len = $urandom_range(9, 63);
            else len = $urandom_range(64, 255);
            q = {q, len[DataWidth-1:0]};
            repeat (len) q = {q, DataWidth'($urandom_range(0, 255))};
        end
        q = {q, DataWidth'(0)};
        repeat (4) q = {q, DataWidth'($urandom_range(0, 255))};
        repeat ($urandom_range(0, 3)) q = {q, DataWidth'($urandom_range(0, 255))};
        return q;
    endfunction

    task automatic send_random_buffer();
        byte_q_t     q;
        int unsigned pick;
        int unsigned cut;
        pick = $urandom_range(99);
        if (pick < 75) begin
            q = make_question();
        end else if (pick < 90) begin
            q = make_question();
            cut = $urandom_range(1, q.size() - 1);
            q = q[0:cut-1];
        end else begin
            repeat ($urandom_range(1, 8)) q = {q, DataWidth'($urandom_range(0, 255))};
        end
        send_buffer(q);
    endtask

    initial begin
        byte_q_t q;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Two labels with extreme characters, extreme type and class, then a byte
        // after completion that re-arms.
        q = '{8'h01, 8'hFF, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55};
        send_buffer(q);
        // Root name with completion on the last byte.
        q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_buffer(q);
        // Label overrun on the length byte and inside a label.
        q = '{8'h05};
        send_buffer(q);
        q = '{8'h02, 8'h61};
        send_buffer(q);
        // A last byte that completes a label leaves the name unterminated.
        q = '{8'h01, 8'h62};
        send_buffer(q);
        // Short tail on the terminator and on a type/class byte.
        q = '{8'h00};
        send_buffer(q);
        q = '{8'h00, 8'h01, 8'h02};
        send_buffer(q);
        // A second length byte that ends the buffer gives the error, not the dot.
        q = '{8'h01, 8'h78, 8'h01};
        send_buffer(q);

        while (requests_sent < 160) send_random_buffer();
        wait_drained();
        while (requests_sent < 250) send_random_buffer();

        send_idle_pct = 86;
        recv_idle_pct = 23;
        while (requests_sent < 480) send_random_buffer();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        while (requests_sent < 620) send_random_buffer();
        wait_drained();
        while (requests_sent < 720) send_random_buffer();

        wait_drained();
        repeat (8) @(negedge aclk);
        if (tracker.error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
